FILE: hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the max tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int VAL_W     = 31;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_COUNT = 2'd2,
    FUNC_TOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
    logic [VAL_W-1:0]     top_value;
    logic [VAL_W-1:0]     max_value;
    logic                 max_valid;
  } rsp_t;

  // one stack entry as held in memory: pushed value and running maximum
  typedef struct packed {
    logic [VAL_W-1:0] data;
    logic [VAL_W-1:0] max;
  } entry_t;

endpackage

FILE: hw/rtl/max_tracking_stack.sv
// ----------------------------------------------------------------------------
// max_tracking_stack
// LIFO stack that reports its largest entry after every request.
// ----------------------------------------------------------------------------
// Done is strobed in the cycle after the request is taken; for a pop that
//   removes an entry, done is strobed from the S_POP state instead.
// Push, read count and read top never raise busy; a pop that removes an entry
//   raises busy in S_POP while the new top entry is read back from the stack
//   memory.
// Reset clears the count and control; the stack memory is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per request.
module max_tracking_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mts_pkg::req_t req,
  output logic          done,
  output mts_pkg::rsp_t rsp
);
  import mts_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [VAL_W-1:0] top_data;  // cached copy of the top entry
  logic [VAL_W-1:0] top_max;
  logic [VAL_W-1:0] pop_data;

  logic             accept;
  logic             empty;
  logic             full;
  logic [VAL_W-1:0] push_max;
  logic [CW-1:0]    cnt_dec2;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;
  logic             ram_we;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  assign busy     = (state == S_POP);
  assign accept   = start && !busy;
  assign empty    = (cnt == '0);
  assign full     = (cnt == CW'(STACK_DEPTH));
  assign push_max = (!empty && top_max > req.value) ? top_max : req.value;
  assign cnt_dec2 = cnt - CW'(2);

  assign ram_we         = accept && req.func == FUNC_PUSH && !full;
  assign ram_wdata.data = req.value;
  assign ram_wdata.max  = push_max;

  mts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (cnt_dec2[AW-1:0]),
    .rdata (ram_rdata)
  );

  // count reported modulo 2^7
  logic [CW-1:0] cnt_rep;
  logic [CW+CNT_OUT_W-1:0] cnt_rep_ext;

  always_comb begin
    cnt_rep = cnt;
    if (state == S_IDLE && accept && req.func == FUNC_PUSH && !full) begin
      cnt_rep = cnt + CW'(1);
    end else if (state == S_IDLE && accept && req.func == FUNC_POP && !empty) begin
      cnt_rep = cnt - CW'(1);
    end
  end

  assign cnt_rep_ext = (CW + CNT_OUT_W)'(cnt_rep);
  assign cnt_ext     = (CW + CNT_OUT_W)'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            done          <= 1'b1;
            rsp.status    <= ST_OK;
            rsp.count     <= cnt_rep_ext[CNT_OUT_W-1:0];
            rsp.top_value <= empty ? '0 : top_data;
            rsp.max_value <= empty ? '0 : top_max;
            rsp.max_valid <= !empty;
            unique case (req.func)
              FUNC_PUSH: begin
                if (full) begin
                  rsp.status <= ST_FULL;
                end else begin
                  cnt           <= cnt + CW'(1);
                  top_data      <= req.value;
                  top_max       <= push_max;
                  rsp.top_value <= req.value;
                  rsp.max_value <= push_max;
                  rsp.max_valid <= 1'b1;
                end
              end
              FUNC_POP: begin
                if (empty) begin
                  rsp.status <= ST_EMPTY;
                end else begin
                  // new top comes back from memory next cycle
                  done     <= 1'b0;
                  cnt      <= cnt - CW'(1);
                  pop_data <= top_data;
                  state    <= S_POP;
                end
              end
              FUNC_COUNT: begin
              end
              FUNC_TOP: begin
                if (empty) begin
                  rsp.status <= ST_EMPTY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          done          <= 1'b1;
          state         <= S_IDLE;
          top_data      <= ram_rdata.data;
          top_max       <= ram_rdata.max;
          rsp.status    <= ST_OK;
          rsp.count     <= cnt_ext[CNT_OUT_W-1:0];
          rsp.top_value <= pop_data;
          rsp.max_value <= empty ? '0 : ram_rdata.max;
          rsp.max_valid <= !empty;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_tracking_stack. A scoreboard predicts every
// response from a shadow copy of the stack and its running maximum. Stimulus
// is a short directed sequence through the empty and re-fill corners, then
// random fill, drain, run-to-full and mixed runs under varying request gaps.
// ----------------------------------------------------------------------------
module tb;
  import mts_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int PHASE_REQS  = 200;

  class stack_scoreboard;
    logic [VAL_W-1:0] data_mem [STACK_DEPTH];
    logic [VAL_W-1:0] max_mem  [STACK_DEPTH];
    int unsigned      depth;
    rsp_t             pending [$];
    int unsigned      errors;

    function new();
      depth  = 0;
      errors = 0;
    endfunction

    // predict the response to an accepted request and queue it
    function void note_request(req_t r);
      rsp_t             e;
      logic [VAL_W-1:0] top;
      logic [VAL_W-1:0] m;
      e        = '0;
      e.status = ST_OK;
      top      = '0;
      if (depth > 0) top = data_mem[depth-1];
      case (r.func)
        FUNC_PUSH: begin
          if (depth >= STACK_DEPTH) begin
            e.status = ST_FULL;
          end else begin
            m = r.value;
            if (depth > 0) begin
              if (max_mem[depth-1] > m) m = max_mem[depth-1];
            end
            data_mem[depth] = r.value;
            max_mem[depth]  = m;
            depth++;
            top = r.value;
          end
        end
        FUNC_POP: begin
          if (depth == 0) e.status = ST_EMPTY;
          else depth--;
        end
        FUNC_TOP: begin
          if (depth == 0) e.status = ST_EMPTY;
        end
        default: ;
      endcase
      e.count     = CNT_OUT_W'(depth);
      e.top_value = top;
      if (depth > 0) begin
        e.max_value = max_mem[depth-1];
        e.max_valid = 1'b1;
      end
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.count !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, got.count);
        errors++;
      end
      if (got.top_value !== e.top_value) begin
        $error("top_value: expected %h, got %h", e.top_value, got.top_value);
        errors++;
      end
      if (got.max_value !== e.max_value) begin
        $error("max_value: expected %h, got %h", e.max_value, got.max_value);
        errors++;
      end
      if (got.max_valid !== e.max_valid) begin
        $error("max_valid: expected %0d, got %0d", e.max_valid, got.max_valid);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  stack_scoreboard sb = new();
  int              est_depth = 0;

  max_tracking_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("max_tracking_stack verification failed");
    $finish;
  end

  // sample handshakes on the pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_response(rsp);
      if (start && !busy) sb.note_request(req);
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return VAL_W'($urandom_range(0, 15));
      3:       return '1 - VAL_W'($urandom_range(0, 15));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send(func_e f, logic [VAL_W-1:0] v);
    start <= 1'b1;
    req   <= '{func: f, value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (f == FUNC_PUSH && est_depth < STACK_DEPTH) est_depth++;
    if (f == FUNC_POP && est_depth > 0) est_depth--;
  endtask

  // drop start and put noise on the request bus
  task automatic pause(int n);
    start <= 1'b0;
    req   <= '{func: func_e'($urandom_range(0, 3)), value: rand_value()};
    repeat (n) @(posedge clk);
  endtask

  task automatic random_phase(int n, int idle_pct);
    int    mode;
    int    left;
    int    roll;
    func_e f;
    left = 0;
    mode = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 90);
      end
      left--;
      roll = $urandom_range(0, 99);
      case (mode)
        0: f = (roll < 85) ? FUNC_PUSH : func_e'($urandom_range(1, 3));
        1: f = (roll < 80) ? FUNC_POP : func_e'($urandom_range(0, 3));
        // run to full, then keep pressing on the full stack
        2: begin
          if (est_depth < STACK_DEPTH || roll < 50) f = FUNC_PUSH;
          else f = func_e'($urandom_range(1, 3));
        end
        default: f = func_e'($urandom_range(0, 3));
      endcase
      // each sender cycle is idle with probability idle_pct
      while ($urandom_range(0, 99) < idle_pct) pause(1);
      send(f, rand_value());
    end
  endtask

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty stack corners
    send(FUNC_TOP, 31'h1234_5678);
    send(FUNC_POP, '1);
    send(FUNC_COUNT, '0);
    // extremes and max tracking across pops
    send(FUNC_PUSH, '0);
    send(FUNC_TOP, '0);
    send(FUNC_PUSH, '1);
    send(FUNC_PUSH, 31'd1);
    send(FUNC_COUNT, '1);
    send(FUNC_TOP, '0);
    send(FUNC_POP, '0);
    send(FUNC_POP, '0);
    send(FUNC_PUSH, 31'h2AAA_AAAA);
    send(FUNC_PUSH, 31'h5555_5555);
    send(FUNC_PUSH, 31'd5);
    send(FUNC_TOP, '0);
    send(FUNC_POP, '0);
    send(FUNC_POP, '0);
    send(FUNC_POP, '0);
    send(FUNC_POP, '0);
    send(FUNC_POP, '0);
    send(FUNC_TOP, '0);
    // an emptied stack must not carry its old maximum
    send(FUNC_PUSH, 31'd9);
    send(FUNC_TOP, '0);
    send(FUNC_POP, '0);

    random_phase(PHASE_REQS, 15);
    random_phase(PHASE_REQS, 59);
    random_phase(PHASE_REQS, 0);

    pause(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("max_tracking_stack verification clean");
    end else begin
      $display("max_tracking_stack verification failed");
    end
    $finish;
  end

endmodule
